>>> rtl/rtpp_pkg.sv
// Package for the port rule text parser.
// Holds parse state and result types, character codes and the protocol words.
// No dependencies.
package rtpp_pkg;

   typedef enum logic [1:0] {
      PH_PROTO,
      PH_LOW,
      PH_HIGH,
      PH_ENDED
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  proto_length;
      logic        tcp_match;
      logic        udp_match;
      logic [15:0] port_acc;
      logic [15:0] low_port;
      logic        digit_seen;
      logic        error_seen;
   } parse_state_type;

   typedef struct packed {
      logic        ok;
      logic        protocol;
      logic [15:0] low;
      logic [15:0] high;
   } rule_result_type;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_BIT     = 8'h20;

   localparam logic [2:0] PROTO_WORD_LEN = 3'd3;
   localparam logic [2:0] PROTO_LEN_SAT  = 3'd4;

   localparam logic [7:0] TCP_WORD [3] = '{"t", "c", "p"};
   localparam logic [7:0] UDP_WORD [3] = '{"u", "d", "p"};

   localparam parse_state_type STATE_RESET = '{
      phase:        PH_PROTO,
      proto_length: 3'd0,
      tcp_match:    1'b1,
      udp_match:    1'b1,
      port_acc:     16'd0,
      low_port:     16'd0,
      digit_seen:   1'b0,
      error_seen:   1'b0
   };

endpackage

>>> rtl/rtpp_parse_step.sv
// Combinational step of the port rule text parser: one byte against the state.
// Gives the next parse state and, for a final byte, the rule result.
// Depends on rtpp_pkg.
module rtpp_parse_step
   import rtpp_pkg::*;
(
   input  parse_state_type state_cur,
   input  logic [7:0]      text_byte,
   input  logic            is_final,
   output parse_state_type state_next,
   output rule_result_type result
);

   function automatic logic field_good(input parse_state_type s);
      return s.digit_seen && (s.port_acc != 16'd0);
   endfunction

   // Close the text: check the open field and move to the ended phase.
   function automatic parse_state_type close_text(input parse_state_type s);
      parse_state_type t;
      t = s;
      if (t.phase != PH_ENDED) begin
         if (!t.error_seen) begin
            if (t.phase == PH_PROTO) begin
               t.error_seen = 1'b1;
            end else if (!field_good(t)) begin
               t.error_seen = 1'b1;
            end else if (t.phase == PH_LOW) begin
               t.low_port = t.port_acc;
            end else if (t.port_acc < t.low_port) begin
               t.error_seen = 1'b1;
            end
         end
         t.phase = PH_ENDED;
      end
      return t;
   endfunction

   parse_state_type s;
   parse_state_type c;
   logic            is_digit;
   logic [7:0]      lower;
   logic [19:0]     product;
   logic [1:0]      pos;

   always_comb begin
      s        = state_cur;
      is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
      lower    = ((text_byte >= CHAR_UPPER_A) && (text_byte <= CHAR_UPPER_Z))
                 ? (text_byte | CASE_BIT) : text_byte;
      // times ten as two shifts and an add; the digit value is the low nibble
      product  = ({4'd0, s.port_acc} << 3) + ({4'd0, s.port_acc} << 1)
                 + {16'd0, text_byte[3:0]};
      pos      = s.proto_length[1:0];

      if (s.phase != PH_ENDED) begin
         if (text_byte == CHAR_NUL) begin
            s = close_text(s);
         end else if (!s.error_seen) begin
            if (s.phase == PH_PROTO) begin
               if (text_byte == CHAR_SLASH) begin
                  if ((s.proto_length != PROTO_WORD_LEN) || !(s.tcp_match || s.udp_match)) begin
                     s.error_seen = 1'b1;
                  end
                  s.phase      = PH_LOW;
                  s.port_acc   = 16'd0;
                  s.digit_seen = 1'b0;
               end else begin
                  if (s.proto_length < PROTO_WORD_LEN) begin
                     if (lower != TCP_WORD[pos]) begin
                        s.tcp_match = 1'b0;
                     end
                     if (lower != UDP_WORD[pos]) begin
                        s.udp_match = 1'b0;
                     end
                  end
                  if (s.proto_length < PROTO_LEN_SAT) begin
                     s.proto_length = s.proto_length + 3'd1;
                  end
               end
            end else if (is_digit) begin
               s.digit_seen = 1'b1;
               if (product[19:16] != 4'd0) begin
                  s.error_seen = 1'b1;
                  s.port_acc   = 16'd0;
               end else begin
                  s.port_acc = product[15:0];
               end
            end else if ((text_byte == CHAR_DASH) && (s.phase == PH_LOW) && field_good(s)) begin
               s.low_port   = s.port_acc;
               s.port_acc   = 16'd0;
               s.digit_seen = 1'b0;
               s.phase      = PH_HIGH;
            end else begin
               s.error_seen = 1'b1;
            end
         end
      end

      c = close_text(s);
      if (c.error_seen) begin
         result = '0;
      end else begin
         result.ok       = 1'b1;
         result.protocol = c.udp_match && !c.tcp_match;
         result.low      = c.low_port;
         result.high     = c.port_acc;
      end

      state_next = is_final ? STATE_RESET : s;
   end

endmodule

>>> rtl/port_rule_text_parser_top.sv
// Top level of the port rule text parser.
// Input register, parse state register and result register around rtpp_parse_step.
// Depends on rtpp_pkg and rtpp_parse_step.
//
// Usage
//   The req_ channel carries the rule text ("tcp/80", "UDP/1000-2000"), one byte per
//   transfer, with req_is_final marking its last byte. A transfer completes on a rising
//   edge with valid high and stall low.
//   The rsp_ channel returns one transfer per final byte: rule_ok, the protocol
//   (0 tcp, 1 udp) and the low and high port; all zero when the text is not a valid rule.
//   Result path: the final byte passes through the input register, then the step result is
//   captured in the result register, which raises rsp_valid.
//   Throughput: one byte per cycle while req_stall is low; the per-byte work is one step of
//   multiply-by-ten, compares and the protocol letter match.
//   Reset (synchronous, active high) empties both registers and returns the parser to
//   the protocol field; after each final byte the parser returns there on its own.
//   Stall: while a result waits under rsp_stall, non-final bytes still flow; a further
//   final byte holds in the input register and req_stall rises until the result goes.
module port_rule_text_parser_top
   import rtpp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_is_final,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_rule_ok,
   output logic        rsp_rule_protocol,
   output logic [15:0] rsp_rule_low,
   output logic [15:0] rsp_rule_high
);

   // input register
   logic            in_valid_ff;
   logic            in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_final_ff;

   // parse state
   parse_state_type parse_state_ff;
   parse_state_type parse_state_in;

   // result register
   logic            out_valid_ff;
   logic            out_valid_in;
   rule_result_type out_result_ff;
   rule_result_type step_result;

   logic            advance;
   logic            take_req;

   rtpp_parse_step u_step (
      .state_cur  (parse_state_ff),
      .text_byte  (in_byte_ff),
      .is_final   (in_final_ff),
      .state_next (parse_state_in),
      .result     (step_result)
   );

   // A held byte moves on unless it is final and the result register is still full and stalled.
   assign advance   = in_valid_ff && (!in_final_ff || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance && in_final_ff) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         parse_state_ff <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // advance the parse state one byte per transfer
         if (advance) begin
            parse_state_ff <= parse_state_in;
         end
      end
   end

   // Payload registers: capture on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_byte_ff  <= req_text_byte;
         in_final_ff <= req_is_final;
      end
      if (advance && in_final_ff) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_rule_ok       = out_result_ff.ok;
   assign rsp_rule_protocol = out_result_ff.protocol;
   assign rsp_rule_low      = out_result_ff.low;
   assign rsp_rule_high     = out_result_ff.high;

endmodule

>>> verif/rtpp_tb_pkg.sv
// Scoreboard for the port rule text parser test: a byte-wise rule parser
// and the queue of rule results still awaited. Depends on rtpp_pkg.
`timescale 1ns / 100ps

package rtpp_tb_pkg;
   import rtpp_pkg::*;

   typedef logic [7:0] text_type [$];

   localparam int unsigned PORT_LIMIT = 65535;

   class rule_expectations;
      rule_result_type awaited_rules [$];
      int unsigned     byte_count;
      int unsigned     text_count;
      int unsigned     valid_count;
      int unsigned     udp_count;
      int unsigned     range_count;
      int unsigned     fail_count;

      // parser state
      phase_type   phase;
      logic [2:0]  word_len;
      logic        tcp_ok;
      logic        udp_ok;
      logic [19:0] acc;
      logic [15:0] low_held;
      logic        have_digit;
      logic        failed;

      function new();
         clear_state();
      endfunction

      function void clear_state();
         phase      = PH_PROTO;
         word_len   = 3'd0;
         tcp_ok     = 1'b1;
         udp_ok     = 1'b1;
         acc        = 20'd0;
         low_held   = 16'd0;
         have_digit = 1'b0;
         failed     = 1'b0;
      endfunction

      function bit port_good();
         return have_digit && acc != 0 && acc <= PORT_LIMIT;
      endfunction

      // End of text: a NUL byte or the final byte.
      function void close_text();
         if (phase == PH_ENDED) return;
         if (!failed) begin
            if (phase == PH_PROTO) failed = 1'b1;
            else if (!port_good()) failed = 1'b1;
            else if (phase == PH_LOW) low_held = acc[15:0];
            else if (acc < low_held) failed = 1'b1;
         end
         phase = PH_ENDED;
      endfunction

      function void parse_byte(logic [7:0] b);
         logic [7:0] c;
         if (phase == PH_ENDED) return;
         if (b == CHAR_NUL) begin
            close_text();
            return;
         end
         if (failed) return;
         if (phase == PH_PROTO) begin
            if (b == CHAR_SLASH) begin
               if (word_len != PROTO_WORD_LEN || !(tcp_ok || udp_ok)) failed = 1'b1;
               phase      = PH_LOW;
               acc        = 20'd0;
               have_digit = 1'b0;
               return;
            end
            if (word_len < PROTO_WORD_LEN) begin
               c = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? (b | CASE_BIT) : b;
               if (c != TCP_WORD[word_len[1:0]]) tcp_ok = 1'b0;
               if (c != UDP_WORD[word_len[1:0]]) udp_ok = 1'b0;
            end
            if (word_len < PROTO_LEN_SAT) word_len++;
            return;
         end
         if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            acc        = 20'(acc * 10 + (b - CHAR_ZERO));
            have_digit = 1'b1;
            if (acc > PORT_LIMIT) begin
               failed = 1'b1;
               acc    = 20'd0;
            end
            return;
         end
         if (b == CHAR_DASH && phase == PH_LOW && port_good()) begin
            low_held   = acc[15:0];
            acc        = 20'd0;
            have_digit = 1'b0;
            phase      = PH_HIGH;
            return;
         end
         failed = 1'b1;
      endfunction

      // Advance the parser by one accepted byte; queue a result on the final one.
      function void note_byte(logic [7:0] b, logic fin);
         rule_result_type r;
         byte_count++;
         parse_byte(b);
         if (!fin) return;
         close_text();
         r = '0;
         if (!failed) begin
            r.ok       = 1'b1;
            r.protocol = udp_ok && !tcp_ok;
            r.low      = low_held;
            r.high     = acc[15:0];
            valid_count++;
            if (r.protocol) udp_count++;
            if (r.low != r.high) range_count++;
         end
         awaited_rules.push_back(r);
         text_count++;
         clear_state();
      endfunction

      function void check_rule(logic ok, logic protocol, logic [15:0] low, logic [15:0] high);
         rule_result_type want;
         if (awaited_rules.size() == 0) begin
            $error("rule result with none awaited: ok %0d protocol %0d low %0d high %0d",
                   ok, protocol, low, high);
            fail_count++;
            return;
         end
         want = awaited_rules.pop_front();
         if (ok !== want.ok) begin
            $error("rule_ok: expected %0d, got %0d", want.ok, ok);
            fail_count++;
         end
         if (protocol !== want.protocol) begin
            $error("rule_protocol: expected %0d, got %0d", want.protocol, protocol);
            fail_count++;
         end
         if (low !== want.low) begin
            $error("rule_low: expected %0d, got %0d", want.low, low);
            fail_count++;
         end
         if (high !== want.high) begin
            $error("rule_high: expected %0d, got %0d", want.high, high);
            fail_count++;
         end
      endfunction

      function int unsigned pending();
         return awaited_rules.size();
      endfunction
   endclass

endpackage

>>> verif/port_rule_text_parser_top_test.sv
// Test of port_rule_text_parser_top: directed rule texts, then random ones under
// four handshake pressure phases. Depends on rtpp_pkg and rtpp_tb_pkg.
`timescale 1ns / 100ps

module port_rule_text_parser_top_test;
   import rtpp_pkg::*;
   import rtpp_tb_pkg::*;

   localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer on either side
   localparam int PHASE_BYTES  = 190;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte = 8'd0;
   logic        req_is_final  = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic        rsp_rule_ok;
   logic        rsp_rule_protocol;
   logic [15:0] rsp_rule_low;
   logic [15:0] rsp_rule_high;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned quiet_cycles  = 0;

   rule_expectations rules = new();

   // Hand-picked texts: good rules at the port extremes, every way a text can be rejected.
   string directed_rules [$] = '{
      "tcp/80", "UDP/1000-2000", "uDp/65535", "tcp/1-65535", "TcP/0007-0007",
      "tcp/65536", "tcp/0", "udp/20-10", "tcp/5-0", "tcp/", "tcp/-5", "tcp/5-",
      "tcp/1-2-3", "tcp/1/2", "tcp/8x", "tcpp/80", "tc/80", "abc/80", "tcp80",
      "/80", "tcp/1234567"
   };

   port_rule_text_parser_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_text_byte     (req_text_byte),
      .req_is_final      (req_is_final),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_rule_ok       (rsp_rule_ok),
      .rsp_rule_protocol (rsp_rule_protocol),
      .rsp_rule_low      (rsp_rule_low),
      .rsp_rule_high     (rsp_rule_high)
   );

   always #5 clock = ~clock;

   // Receiver: stall at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Check every result transfer and watch for a hang. Values read here are the
   // ones from before the edge, the same ones the block acts on.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         rules.check_rule(rsp_rule_ok, rsp_rule_protocol, rsp_rule_low, rsp_rule_high);
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d results awaited",
                  QUIET_LIMIT, rules.pending());
         $display("** port_rule_text_parser_top: FAILED **");
         $finish;
      end
   end

   function automatic text_type str_bytes(input string s);
      text_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   // Bias stray bytes towards the separators, which the parser treats specially.
   function automatic logic [7:0] stray_byte();
      case ($urandom_range(3))
         0:       return CHAR_DASH;
         1:       return CHAR_SLASH;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic int unsigned pick_port();
      case ($urandom_range(9))
         0:       return $urandom_range(9, 1);
         1, 2:    return $urandom_range(999, 1);
         7:       return $urandom_range(PORT_LIMIT, PORT_LIMIT - 1);
         8:       return $urandom_range(999999, PORT_LIMIT + 1);
         9:       return 0;
         default: return $urandom_range(PORT_LIMIT, 1);
      endcase
   endfunction

   function automatic text_type port_text(input int unsigned v);
      text_type t;
      if ($urandom_range(9) == 0) repeat ($urandom_range(3, 1)) t.push_back(CHAR_ZERO);
      t = {t, str_bytes($sformatf("%0d", v))};
      return t;
   endfunction

   // Mostly well-formed rules with random case and ports; some mangled, a few pure noise.
   function automatic text_type make_text();
      text_type    t;
      int unsigned lo;
      int unsigned hi;
      int unsigned pos;
      string       word;
      if ($urandom_range(99) < 5) begin
         repeat ($urandom_range(6, 1)) t.push_back(8'($urandom_range(255)));
         return t;
      end
      if ($urandom_range(99) < 6) begin
         repeat ($urandom_range(5)) t.push_back(8'(CHAR_UPPER_A + $urandom_range(25)) |
                                                ($urandom_range(1) ? CASE_BIT : 8'h00));
      end else begin
         word = $urandom_range(1) ? "udp" : "tcp";
         for (int i = 0; i < 3; i++)
            t.push_back($urandom_range(1) ? (word[i] ^ CASE_BIT) : word[i]);
      end
      t.push_back(CHAR_SLASH);
      lo = pick_port();
      t  = {t, port_text(lo)};
      if ($urandom_range(1)) begin
         case ($urandom_range(9))
            0:       hi = lo;
            1, 2:    hi = pick_port();
            default: hi = $urandom_range(PORT_LIMIT, lo);
         endcase
         t.push_back(CHAR_DASH);
         t = {t, port_text(hi)};
      end
      if ($urandom_range(99) < 20) begin
         pos = $urandom_range(t.size() - 1);
         case ($urandom_range(4))
            0:       t.insert(pos, stray_byte());
            1:       t[pos] = stray_byte();
            2:       t.delete(pos);
            3:       t = t[0:pos];
            default: begin
               t.insert(pos, CHAR_NUL);
               repeat ($urandom_range(3)) t.push_back(8'($urandom_range(255)));
            end
         endcase
         if (t.size() == 0) t.push_back(stray_byte());
      end
      return t;
   endfunction

   // Offer one byte; hold it until the block takes it.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_is_final  <= fin;
      do @(posedge clock); while (req_stall !== 1'b0);
      rules.note_byte(b, fin);
   endtask

   task automatic send_text(input text_type t);
      for (int i = 0; i < t.size(); i++) send_byte(t[i], i == t.size() - 1);
   endtask

   // Drop valid and hold off until every awaited result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (rules.pending() != 0);
   endtask

   initial begin
      text_type    t;
      int unsigned target;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed texts, no idling on either side.
      foreach (directed_rules[i]) send_text(str_bytes(directed_rules[i]));
      // NUL as the final byte still closes a good rule.
      t = str_bytes("udp/53");
      t.push_back(CHAR_NUL);
      send_text(t);
      // Bytes after a NUL are ignored, final byte included.
      t = str_bytes("tcp/80");
      t.push_back(CHAR_NUL);
      t = {t, str_bytes("zz9")};
      send_text(t);
      // NUL inside the protocol word leaves no slash: invalid.
      t = str_bytes("tc");
      t.push_back(CHAR_NUL);
      t = {t, str_bytes("p/1")};
      send_text(t);
      // A lone NUL and a lone 0xFF, both final.
      send_byte(CHAR_NUL, 1'b1);
      send_byte(8'hFF, 1'b1);
      t = str_bytes("tcp/");
      t.push_back(8'hFF);
      send_text(t);
      wait_drained();

      // Random phases: free flow, idle sender, stalling receiver, light mix of both.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 86; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 86; end
            default: begin send_idle_pct = 8;  stall_pct = 8;  end
         endcase
         target = rules.byte_count + PHASE_BYTES;
         while (rules.byte_count < target) send_text(make_text());
         wait_drained();
      end

      // Let any straggler show up before the verdict.
      stall_pct = 0;
      repeat (10) @(posedge clock);

      $display("Covered %0d texts in %0d bytes: %0d valid (%0d udp, %0d ranges), %0d rejected.",
               rules.text_count, rules.byte_count, rules.valid_count, rules.udp_count,
               rules.range_count, rules.text_count - rules.valid_count);
      $display("Ran free flow, idle sender, stalling receiver and light mixed pressure phases.");
      if (rules.fail_count == 0 && rules.pending() == 0)
         $display("** port_rule_text_parser_top: PASSED **");
      else
         $display("** port_rule_text_parser_top: FAILED **");
      $finish;
   end

endmodule
